// ----- hdl/int32_alu_with_overflow_top_assert.svh -----
// ----------------------------------------------------------------------------
// Integer ALU assertion macros
// Shared property forms for the ALU pipeline checks.
// ----------------------------------------------------------------------------
`ifndef INT32_ALU_WITH_OVERFLOW_TOP_ASSERT_SVH
`define INT32_ALU_WITH_OVERFLOW_TOP_ASSERT_SVH

// same-cycle implication
`define IALU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ialu check failed");

// next-cycle implication
`define IALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ialu check failed");

`endif

// ----- hdl/ialu_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer ALU package
// Opcodes and widths shared by the ALU pipeline.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int XLEN      = 32;
  localparam int OPW       = 6;
  localparam int DIV_STEPS = XLEN;

  typedef enum logic [OPW-1:0] {
    OP_ADD   = 6'd0,
    OP_SUB   = 6'd1,
    OP_MUL   = 6'd2,
    OP_DIV   = 6'd3,
    OP_EXP   = 6'd4,
    OP_MOD   = 6'd5,
    OP_AND   = 6'd6,
    OP_OR    = 6'd7,
    OP_XNOR  = 6'd8,
    OP_XOR   = 6'd9,
    OP_LSL   = 6'd10,
    OP_ASL   = 6'd11,
    OP_ASR   = 6'd12,
    OP_LSR   = 6'd13,
    OP_EQS   = 6'd14,
    OP_EQ    = 6'd15,
    OP_NEQS  = 6'd16,
    OP_NEQ   = 6'd17,
    OP_LT    = 6'd18,
    OP_GT    = 6'd19,
    OP_LE    = 6'd20,
    OP_GE    = 6'd21,
    OP_LAND  = 6'd22,
    OP_LOR   = 6'd23,
    OP_UPLUS = 6'd24,
    OP_UNEG  = 6'd25,
    OP_NOT   = 6'd26,
    OP_LNOT  = 6'd27,
    OP_RAND  = 6'd28,
    OP_ROR   = 6'd29,
    OP_RNAND = 6'd30,
    OP_RNOR  = 6'd31,
    OP_RXOR  = 6'd32,
    OP_RXNOR = 6'd33,
    OP_MAX   = 6'd34
  } op_t;

  localparam logic [XLEN-1:0] INT_MIN = {1'b1, {(XLEN-1){1'b0}}};

endpackage

// ----- hdl/int32_alu_with_overflow_top.sv -----
// ----------------------------------------------------------------------------
// Integer ALU with overflow detection
// Pipelined 32-bit ALU: one operation per cycle, multiplier and divider staged.
// ----------------------------------------------------------------------------
//  channel   ports                                         handshake
//  input     in_opcode in_operand_a in_operand_b           start, busy
//            in_signed_shift
//  result    out_result out_overflow                       out_strobe
//
//  Every opcode passes through the same registers from accept to out_strobe: the
//  input register, the decode stage, the 32 one-bit divider stages and the output register.
//  A new transaction is taken every cycle; busy stays low.
//  Reset clears all valid bits; nothing is in flight afterwards.
//  The receiver cannot stall; each result shows for one cycle.
module int32_alu_with_overflow_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ialu_pkg::OPW-1:0]    in_opcode,
  input  logic signed [ialu_pkg::XLEN-1:0] in_operand_a,
  input  logic signed [ialu_pkg::XLEN-1:0] in_operand_b,
  input  logic                        in_signed_shift,
  output logic                        out_strobe,
  output logic signed [ialu_pkg::XLEN-1:0] out_result,
  output logic                        out_overflow
);

  localparam int W = ialu_pkg::XLEN;
  localparam int N = ialu_pkg::DIV_STEPS;

  logic                       v1_r;
  logic [ialu_pkg::OPW-1:0]   op1_r;
  logic [W-1:0]               a1_r;
  logic [W-1:0]               b1_r;
  logic                       sgn1_r;

  logic [W-1:0]               res_nxt;
  logic                       ov_nxt;
  logic signed [2*W-1:0]      prod_r;

  logic                       v_r    [0:N];
  logic [ialu_pkg::OPW-1:0]   op_r   [0:N];
  logic [W-1:0]               res_r  [0:N];
  logic                       ov_r   [0:N];
  logic                       qneg_r [0:N];
  logic                       rneg_r [0:N];
  logic                       dz_r   [0:N];
  logic                       dovf_r [0:N];
  logic [W-1:0]               dvs_r  [0:N];
  logic [W-1:0]               dq_r   [0:N];
  logic [W-1:0]               rem_r  [0:N];

  logic                       vout_r;
  logic [W-1:0]               rout_r;
  logic                       oout_r;

  logic [W-1:0]               sum;
  logic [W-1:0]               diff;
  logic                       shift_ok;
  logic [4:0]                 sh;
  logic [W-1:0]               shl;
  logic [W-1:0]               sra;
  logic [5:0]                 sh_back;
  logic                       shl_ov;
  logic                       lt;
  logic                       eq;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    op1_r  <= in_opcode;
    a1_r   <= in_operand_a;
    b1_r   <= in_operand_b;
    sgn1_r <= in_signed_shift;
  end

  assign sum      = a1_r + b1_r;
  assign diff     = a1_r - b1_r;
  assign shift_ok = (b1_r[W-1:5] == '0);
  assign sh       = b1_r[4:0];
  assign shl      = a1_r << sh;
  assign sra      = $signed(a1_r) >>> sh;
  assign sh_back  = 6'd32 - {1'b0, sh};
  assign shl_ov   = (($signed(a1_r) >>> sh_back) != 0) || (shl[W-1] != a1_r[W-1]);
  assign lt       = $signed(a1_r) < $signed(b1_r);
  assign eq       = a1_r == b1_r;

  always_comb begin
    res_nxt = '0;
    ov_nxt  = 1'b0;
    case (op1_r) inside
      ialu_pkg::OP_ADD: begin
        res_nxt = sum;
        ov_nxt  = (~(a1_r[W-1] ^ b1_r[W-1])) & (a1_r[W-1] ^ sum[W-1]);
      end
      ialu_pkg::OP_SUB: begin
        res_nxt = diff;
        ov_nxt  = (a1_r[W-1] ^ b1_r[W-1]) & (a1_r[W-1] ^ diff[W-1]);
      end
      ialu_pkg::OP_MUL, ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
        res_nxt = '0;
      end
      ialu_pkg::OP_AND:  res_nxt = a1_r & b1_r;
      ialu_pkg::OP_OR:   res_nxt = a1_r | b1_r;
      ialu_pkg::OP_XNOR: res_nxt = ~(a1_r ^ b1_r);
      ialu_pkg::OP_XOR:  res_nxt = a1_r ^ b1_r;
      ialu_pkg::OP_LSL, ialu_pkg::OP_ASL: begin
        if (!shift_ok) begin
          res_nxt = '0;
        end else if (sh == 5'd0) begin
          res_nxt = a1_r;
        end else begin
          res_nxt = shl;
          ov_nxt  = shl_ov;
        end
      end
      ialu_pkg::OP_ASR: begin
        if (sgn1_r) begin
          res_nxt = shift_ok ? sra : {W{a1_r[W-1]}};
        end else begin
          res_nxt = shift_ok ? (a1_r >> sh) : '0;
        end
      end
      ialu_pkg::OP_LSR:   res_nxt = shift_ok ? (a1_r >> sh) : '0;
      ialu_pkg::OP_EQS, ialu_pkg::OP_EQ:   res_nxt = W'(eq);
      ialu_pkg::OP_NEQS, ialu_pkg::OP_NEQ: res_nxt = W'(!eq);
      ialu_pkg::OP_LT:    res_nxt = W'(lt);
      ialu_pkg::OP_GT:    res_nxt = W'(!lt && !eq);
      ialu_pkg::OP_LE:    res_nxt = W'(lt || eq);
      ialu_pkg::OP_GE:    res_nxt = W'(!lt);
      ialu_pkg::OP_LAND:  res_nxt = W'((a1_r != '0) && (b1_r != '0));
      ialu_pkg::OP_LOR:   res_nxt = W'((a1_r != '0) || (b1_r != '0));
      ialu_pkg::OP_UPLUS: res_nxt = a1_r;
      ialu_pkg::OP_UNEG:  res_nxt = '0 - a1_r;
      ialu_pkg::OP_NOT:   res_nxt = ~a1_r;
      ialu_pkg::OP_LNOT, ialu_pkg::OP_RNOR: res_nxt = W'(a1_r == '0);
      ialu_pkg::OP_RAND:  res_nxt = W'(&a1_r);
      ialu_pkg::OP_ROR:   res_nxt = W'(|a1_r);
      ialu_pkg::OP_RNAND: res_nxt = W'(!(&a1_r));
      ialu_pkg::OP_MAX:   res_nxt = lt ? b1_r : a1_r;
      default:            ov_nxt  = 1'b1;
    endcase
  end

  // stage 2: decode results, product, divider setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= v1_r;
    end
    op_r[0]   <= op1_r;
    res_r[0]  <= res_nxt;
    ov_r[0]   <= ov_nxt;
    prod_r    <= $signed(a1_r) * $signed(b1_r);
    qneg_r[0] <= a1_r[W-1] ^ b1_r[W-1];
    rneg_r[0] <= a1_r[W-1];
    dz_r[0]   <= (b1_r == '0);
    dovf_r[0] <= (a1_r == ialu_pkg::INT_MIN) && (b1_r == '1);
    dvs_r[0]  <= b1_r[W-1] ? ('0 - b1_r) : b1_r;
    dq_r[0]   <= a1_r[W-1] ? ('0 - a1_r) : a1_r;
    rem_r[0]  <= '0;
  end

  // divider: one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_div
    logic [W:0]   trial;
    logic [W:0]   shifted;
    logic [W-1:0] res_in;
    logic         ov_in;

    assign shifted = {rem_r[k], dq_r[k][W-1]};
    assign trial   = shifted - {1'b0, dvs_r[k]};

    if (k == 0) begin : g_mul
      assign res_in = (op_r[0] == ialu_pkg::OP_MUL) ? prod_r[W-1:0] : res_r[0];
      assign ov_in  = (op_r[0] == ialu_pkg::OP_MUL)
                    ? !((prod_r[2*W-1:W-1] == '0) || (prod_r[2*W-1:W-1] == '1))
                    : ov_r[0];
    end else begin : g_pass
      assign res_in = res_r[k];
      assign ov_in  = ov_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
      op_r[k+1]   <= op_r[k];
      res_r[k+1]  <= res_in;
      ov_r[k+1]   <= ov_in;
      qneg_r[k+1] <= qneg_r[k];
      rneg_r[k+1] <= rneg_r[k];
      dz_r[k+1]   <= dz_r[k];
      dovf_r[k+1] <= dovf_r[k];
      dvs_r[k+1]  <= dvs_r[k];
      if (!trial[W]) begin
        rem_r[k+1] <= trial[W-1:0];
        dq_r[k+1]  <= {dq_r[k][W-2:0], 1'b1};
      end else begin
        rem_r[k+1] <= shifted[W-1:0];
        dq_r[k+1]  <= {dq_r[k][W-2:0], 1'b0};
      end
    end
  end

  logic [W-1:0] quo_fix;
  logic [W-1:0] rem_fix;
  logic [W-1:0] rout_nxt;
  logic         oout_nxt;

  assign quo_fix = qneg_r[N] ? ('0 - dq_r[N]) : dq_r[N];
  assign rem_fix = rneg_r[N] ? ('0 - rem_r[N]) : rem_r[N];

  always_comb begin
    rout_nxt = res_r[N];
    oout_nxt = ov_r[N];
    if (op_r[N] == ialu_pkg::OP_DIV) begin
      if (dz_r[N]) begin
        rout_nxt = '0;
        oout_nxt = 1'b1;
      end else if (dovf_r[N]) begin
        rout_nxt = ialu_pkg::INT_MIN;
        oout_nxt = 1'b1;
      end else begin
        rout_nxt = quo_fix;
        oout_nxt = 1'b0;
      end
    end else if (op_r[N] == ialu_pkg::OP_MOD) begin
      if (dz_r[N] || dovf_r[N]) begin
        rout_nxt = '0;
        oout_nxt = 1'b1;
      end else begin
        rout_nxt = rem_fix;
        oout_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= v_r[N];
    end
    rout_r <= rout_nxt;
    oout_r <= oout_nxt;
  end

  assign out_strobe   = vout_r;
  assign out_result   = rout_r;
  assign out_overflow = oout_r;

`include "int32_alu_with_overflow_top_assert.svh"

  `IALU_ASSERT_NEXT(a_accept_enters, start && !busy, v1_r)
  `IALU_ASSERT_NEXT(a_last_to_out, v_r[N], out_strobe)
  `IALU_ASSERT_NEXT(a_divzero, v_r[N] && dz_r[N] && (op_r[N] == ialu_pkg::OP_DIV), out_overflow && (out_result == '0))
  `IALU_ASSERT_NOW(a_never_busy, 1'b1, !busy)

endmodule
